@@ hdl/mwcu_pkg.sv @@
// ----------------------------------------------------------------------------
// mwcu_pkg
// Shared types, constants and helper functions for the weighted control
// update block.
// ----------------------------------------------------------------------------
package mwcu_pkg;

    localparam int SAMPLES_DEF = 512;
    localparam int HORIZON_DEF = 128;

    localparam int COST_W    = 32;
    localparam int CTRL_W    = 16;
    localparam int WEIGHT_W  = 16;
    localparam int WSUM_W    = 32;
    localparam int ACC_W     = 48;
    localparam int QUO_W     = ACC_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // item modes
    localparam logic [1:0] MODE_COST = 2'd0;
    localparam logic [1:0] MODE_CTRL = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INV_LAMBDA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_MIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_MAX   = 3'd4;

    localparam logic [15:0]        INV_LAMBDA_RST = 16'd2133;
    localparam logic signed [15:0] SPEED_MIN_RST  = -16'sd410;
    localparam logic signed [15:0] SPEED_MAX_RST  = 16'sd4096;
    localparam logic signed [15:0] TURN_MIN_RST   = -16'sd3686;
    localparam logic signed [15:0] TURN_MAX_RST   = 16'sd3686;

    localparam logic signed [COST_W-1:0] COST_MAX = 32'sh7fff_ffff;
    localparam logic [WEIGHT_W-1:0]      WEIGHT_FULL = 16'hffff;
    localparam logic [47:0]              X_LIMIT = 48'd786432;  // 12 in q.16
    localparam logic [16:0]              LOG2E_Q16 = 17'd94548;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // 2^(-k/16) in q16, k = 0..16
    function automatic logic [16:0] pow2_neg(input logic [4:0] k);
        logic [16:0] v;
        unique case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

    // raise to lo, then lower to hi
    function automatic logic signed [CTRL_W-1:0] clamp_q(
        input logic signed [QUO_W-1:0]  v,
        input logic signed [CTRL_W-1:0] lo,
        input logic signed [CTRL_W-1:0] hi
    );
        logic signed [QUO_W-1:0] r;
        r = v;
        if (r < QUO_W'(lo))
            r = QUO_W'(lo);
        if (r > QUO_W'(hi))
            r = QUO_W'(hi);
        return r[CTRL_W-1:0];
    endfunction

endpackage

@@ hdl/mwcu_if.sv @@
// ----------------------------------------------------------------------------
// mwcu_item_if / mwcu_result_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface mwcu_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [8:0]         sample_index;
    logic [6:0]         step_index;
    logic signed [31:0] cost;
    logic signed [15:0] speed_sample;
    logic signed [15:0] turn_sample;
    logic               first_sample;

    modport source (output valid, mode, sample_index, step_index, cost,
                    speed_sample, turn_sample, first_sample, input ready);
    modport sink   (input valid, mode, sample_index, step_index, cost,
                    speed_sample, turn_sample, first_sample, output ready);
endinterface

interface mwcu_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] speed_opt;
    logic signed [15:0] turn_opt;

    modport source (output valid, speed_opt, turn_opt, input ready);
    modport sink   (input valid, speed_opt, turn_opt, output ready);
endinterface

@@ hdl/mwcu_ram.sv @@
// ----------------------------------------------------------------------------
// mwcu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mwcu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

@@ hdl/mwcu_div.sv @@
// ----------------------------------------------------------------------------
// mwcu_div
// Restoring divider, signed dividend by unsigned divisor, one quotient bit
// per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module mwcu_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [mwcu_pkg::ACC_W-1:0]   dividend,
    input  logic [mwcu_pkg::WSUM_W-1:0]         divisor,
    output mwcu_pkg::div_status_t               status,
    output logic signed [mwcu_pkg::QUO_W-1:0]   quotient
);
    import mwcu_pkg::*;

    localparam int CNT_W = $clog2(ACC_W);

    logic [ACC_W-1:0]  work_reg, work_next;
    logic [WSUM_W-1:0] rem_reg, rem_next;
    logic [WSUM_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [WSUM_W:0]   rem_sh;
    logic              ge;
    logic [ACC_W-1:0]  mag;

    assign mag    = dividend[ACC_W-1] ? ACC_W'(~dividend + 1'b1) : dividend;
    assign rem_sh = {rem_reg, work_reg[ACC_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = ge ? WSUM_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[WSUM_W-1:0];
        work_next = {work_reg[ACC_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ACC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= mag;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            neg_reg  <= dividend[ACC_W-1];
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign quotient    = neg_reg ? -$signed({1'b0, work_reg}) : $signed({1'b0, work_reg});
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ hdl/mppi_weighted_control_update.sv @@
// ----------------------------------------------------------------------------
// mppi_weighted_control_update
// Path-integral control update: cost store with running minimum, per-sample
// exponential weights, per-step weighted accumulators and clamped read-out.
//
//   channel  dir  handshake        payload
//   item     in   valid/ready      mode, sample/step index, cost, controls
//   result   out  valid/ready      speed_opt, turn_opt
//   cfg      in   cfg_we           cfg_index, cfg_data
//
// cost load: the block stays in IDLE. control pair: AMUL then AADD, and at
// step 0 first the multiply and exponent stages that form the weight. step
// read: DLOAD, then the bit-serial divider (48 steps). accumulators lie in
// one RAM and costs in another; the accumulators are read-modify-write.
// reset clears the accumulator valid bits at once; no clearing pass. the
// result register lets new items in while a result waits to be taken.
// ----------------------------------------------------------------------------
module mppi_weighted_control_update #(
    parameter int SAMPLES = mwcu_pkg::SAMPLES_DEF,
    parameter int HORIZON = mwcu_pkg::HORIZON_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mwcu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mwcu_pkg::CFG_DAT_W-1:0]    cfg_data,
    mwcu_item_if.sink                         item,
    mwcu_result_if.source                     result
);
    import mwcu_pkg::*;

    localparam int SA_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int HA_W = (HORIZON > 1) ? $clog2(HORIZON) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WDIFF = 4'd1;
    localparam logic [3:0] S_WMUL  = 4'd2;
    localparam logic [3:0] S_WLOG  = 4'd3;
    localparam logic [3:0] S_WEXP  = 4'd4;
    localparam logic [3:0] S_AMUL  = 4'd5;
    localparam logic [3:0] S_AADD  = 4'd6;
    localparam logic [3:0] S_DLOAD = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;

    logic [3:0] state_reg, state_next;

    // configuration
    logic [15:0]        inv_lambda_reg;
    logic signed [15:0] speed_min_reg, speed_max_reg, turn_min_reg, turn_max_reg;

    // run state
    logic signed [COST_W-1:0] min_reg, min_next;
    logic [WSUM_W-1:0]        wsum_reg, wsum_next;
    logic [WEIGHT_W-1:0]      cur_w_reg, cur_w_next;
    logic [HORIZON-1:0]       vld_reg, vld_next;

    // item capture and datapath
    logic [HA_W-1:0]          step_reg;
    logic                     t_ok_reg;
    logic signed [CTRL_W-1:0] spd_reg, trn_reg;
    logic [31:0]              d_reg;
    logic                     wfull_reg, wzero_reg;
    logic [19:0]              x_reg;
    logic [20:0]              y_reg;
    logic signed [32:0]       sp_prod_reg, tu_prod_reg;

    // output register
    logic                     out_valid_reg;
    logic signed [CTRL_W-1:0] spd_out_reg, trn_out_reg;

    logic        accept;
    logic [31:0] s_ext, t_ext;
    logic        s_ok, t_ok;

    // memories
    logic                     cost_we, cost_re;
    logic [SA_W-1:0]          cost_waddr, cost_raddr;
    logic [COST_W-1:0]        cost_q;
    logic                     acc_we, acc_re;
    logic [HA_W-1:0]          acc_raddr;
    logic [2*ACC_W-1:0]       acc_wdata, acc_q;

    // weight datapath
    logic signed [32:0]       d_full;
    logic [47:0]              x_full;
    logic [36:0]              y_full;
    logic [4:0]               w_n, w_k;
    logic [11:0]              w_r;
    logic [16:0]              t_k, t_k1, m_val, m_sh;
    logic [28:0]              interp;
    logic [WEIGHT_W-1:0]      w_val;

    // accumulate / read
    logic [ACC_W-1:0]         old_sp, old_tu, new_sp, new_tu;
    logic                     dstart;
    div_status_t              sp_stat, tu_stat;
    logic signed [QUO_W-1:0]  sp_quo, tu_quo, sp_q, tu_q;
    logic                     out_load;

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign s_ext      = 32'(item.sample_index);
    assign t_ext      = 32'(item.step_index);
    assign s_ok       = s_ext < 32'(SAMPLES);
    assign t_ok       = t_ext < 32'(HORIZON);

    // cost store
    assign cost_we    = accept && (item.mode == MODE_COST) && s_ok;
    assign cost_waddr = s_ext[SA_W-1:0];
    assign cost_re    = accept && (item.mode == MODE_CTRL) && s_ok && t_ok && (t_ext == 32'd0);
    assign cost_raddr = s_ext[SA_W-1:0];

    mwcu_ram #(.WIDTH(COST_W), .DEPTH(SAMPLES)) u_cost_ram (
        .clk   (clk),
        .we    (cost_we),
        .waddr (cost_waddr),
        .wdata (item.cost),
        .re    (cost_re),
        .raddr (cost_raddr),
        .rdata (cost_q)
    );

    // accumulator store: speed in the upper half, turn in the lower
    assign acc_re    = accept && t_ok &&
                       (((item.mode == MODE_CTRL) && s_ok) || (item.mode == MODE_READ));
    assign acc_raddr = t_ext[HA_W-1:0];
    assign acc_we    = (state_reg == S_AADD);
    assign acc_wdata = {new_sp, new_tu};

    mwcu_ram #(.WIDTH(2 * ACC_W), .DEPTH(HORIZON)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (step_reg),
        .wdata (acc_wdata),
        .re    (acc_re),
        .raddr (acc_raddr),
        .rdata (acc_q)
    );

    // weight stages
    always_comb
    begin
        d_full = 33'($signed(cost_q)) - 33'(min_reg);
        x_full = 48'(d_reg) * 48'(inv_lambda_reg);
        y_full = 37'(x_reg) * 37'(LOG2E_Q16);
        w_n    = y_reg[20:16];
        w_k    = {1'b0, y_reg[15:12]};
        w_r    = y_reg[11:0];
        t_k    = pow2_neg(w_k);
        t_k1   = pow2_neg(w_k + 5'd1);
        interp = 29'(t_k - t_k1) * 29'(w_r);
        m_val  = t_k - interp[28:12];
        m_sh   = m_val >> w_n;
        if (wfull_reg)
            w_val = WEIGHT_FULL;
        else if (wzero_reg)
            w_val = '0;
        else if (m_sh[16])
            w_val = WEIGHT_FULL;
        else
            w_val = m_sh[15:0];
    end

    // accumulate
    always_comb
    begin
        old_sp = vld_reg[step_reg] ? acc_q[2*ACC_W-1:ACC_W] : '0;
        old_tu = vld_reg[step_reg] ? acc_q[ACC_W-1:0] : '0;
        new_sp = old_sp + ACC_W'(sp_prod_reg);
        new_tu = old_tu + ACC_W'(tu_prod_reg);
    end

    assign dstart = (state_reg == S_DLOAD);

    mwcu_div u_div_speed (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dstart),
        .dividend ((t_ok_reg && vld_reg[step_reg]) ? acc_q[2*ACC_W-1:ACC_W] : '0),
        .divisor  (wsum_reg),
        .status   (sp_stat),
        .quotient (sp_quo)
    );

    mwcu_div u_div_turn (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dstart),
        .dividend ((t_ok_reg && vld_reg[step_reg]) ? acc_q[ACC_W-1:0] : '0),
        .divisor  (wsum_reg),
        .status   (tu_stat),
        .quotient (tu_quo)
    );

    assign sp_q     = (wsum_reg == '0) ? '0 : sp_quo;
    assign tu_q     = (wsum_reg == '0) ? '0 : tu_quo;
    assign out_load = (state_reg == S_DIV) && !sp_stat.busy && !tu_stat.busy &&
                      (!out_valid_reg || result.ready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        min_next   = min_reg;
        wsum_next  = wsum_reg;
        cur_w_next = cur_w_reg;
        vld_next   = vld_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.mode != MODE_NONE))
                begin
                    if (item.first_sample)
                    begin
                        min_next  = COST_MAX;
                        wsum_next = '0;
                        vld_next  = '0;
                    end
                    unique case (item.mode)
                        MODE_COST:
                        begin
                            if (s_ok && (item.cost < min_next))
                                min_next = item.cost;
                        end
                        MODE_CTRL:
                        begin
                            if (s_ok && t_ok)
                                state_next = (t_ext == 32'd0) ? S_WDIFF : S_AMUL;
                        end
                        default:
                            state_next = S_DLOAD;
                    endcase
                end
            end
            S_WDIFF: state_next = S_WMUL;
            S_WMUL:  state_next = S_WLOG;
            S_WLOG:  state_next = S_WEXP;
            S_WEXP:
            begin
                cur_w_next = w_val;
                wsum_next  = wsum_reg + WSUM_W'(w_val);
                state_next = S_AMUL;
            end
            S_AMUL:  state_next = S_AADD;
            S_AADD:
            begin
                vld_next[step_reg] = 1'b1;
                state_next = S_IDLE;
            end
            S_DLOAD: state_next = S_DIV;
            S_DIV:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            min_reg        <= COST_MAX;
            wsum_reg       <= '0;
            cur_w_reg      <= '0;
            vld_reg        <= '0;
            out_valid_reg  <= 1'b0;
            inv_lambda_reg <= INV_LAMBDA_RST;
            speed_min_reg  <= SPEED_MIN_RST;
            speed_max_reg  <= SPEED_MAX_RST;
            turn_min_reg   <= TURN_MIN_RST;
            turn_max_reg   <= TURN_MAX_RST;
        end
        else
        begin
            state_reg <= state_next;
            min_reg   <= min_next;
            wsum_reg  <= wsum_next;
            cur_w_reg <= cur_w_next;
            vld_reg   <= vld_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_INV_LAMBDA: inv_lambda_reg <= cfg_data;
                    REG_SPEED_MIN:  speed_min_reg  <= $signed(cfg_data);
                    REG_SPEED_MAX:  speed_max_reg  <= $signed(cfg_data);
                    REG_TURN_MIN:   turn_min_reg   <= $signed(cfg_data);
                    REG_TURN_MAX:   turn_max_reg   <= $signed(cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            step_reg <= t_ext[HA_W-1:0];
            t_ok_reg <= t_ok;
            spd_reg  <= item.speed_sample;
            trn_reg  <= item.turn_sample;
        end
        // d <= 0 means full weight
        wfull_reg <= (d_full <= 33'sd0);
        if (state_reg == S_WDIFF)
            d_reg <= d_full[31:0];
        wzero_reg <= (state_reg == S_WMUL) ? (x_full >= X_LIMIT) : wzero_reg;
        x_reg     <= x_full[19:0];
        y_reg     <= y_full[36:16];
        sp_prod_reg <= $signed({1'b0, cur_w_reg}) * 33'(spd_reg);
        tu_prod_reg <= $signed({1'b0, cur_w_reg}) * 33'(trn_reg);
        if (out_load)
        begin
            spd_out_reg <= clamp_q(sp_q, speed_min_reg, speed_max_reg);
            trn_out_reg <= clamp_q(tu_q, turn_min_reg, turn_max_reg);
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.speed_opt = spd_out_reg;
    assign result.turn_opt  = trn_out_reg;

endmodule

@@ hdl/mwcu_checker.sv @@
// ----------------------------------------------------------------------------
// mwcu_checker
// Port-level checks on the weighted control update, bound to the top level.
// ----------------------------------------------------------------------------
module mwcu_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              item_valid,
    input logic                              item_ready,
    input logic [1:0]                        item_mode,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic signed [15:0]                speed_opt,
    input logic signed [15:0]                turn_opt
);
    import mwcu_pkg::*;

    logic       rd_beat, res_beat;
    logic [1:0] pend_reg;

    assign rd_beat  = item_valid && item_ready && (item_mode == MODE_READ);
    assign res_beat = result_valid && result_ready;

    // reads accepted whose result is not yet taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_reg + 2'(rd_beat) - 2'(res_beat);
    end

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pend_reg != 2'd0))
        else $error("result beat with no read outstanding");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 2'd2)
        else $error("more than two reads outstanding");

    a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rd_beat |=> !item_ready)
        else $error("item taken right after a read beat");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(speed_opt) && $stable(turn_opt)))
        else $error("stalled result changed or dropped");

endmodule

bind mppi_weighted_control_update mwcu_checker u_mwcu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_mode    (item.mode),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .speed_opt    (result.speed_opt),
    .turn_opt     (result.turn_opt)
);

@@ verif/mppi_weighted_control_update_tb.sv @@
// ----------------------------------------------------------------------------
// mppi_weighted_control_update_tb
// Self-checking bench for the weighted control update. A directed table
// covers register resets, field extremes and the weight corner cases. Random
// cost/control/read runs follow under several clamp and lambda settings.
// Read results are checked against a local model or a value in the table.
// ----------------------------------------------------------------------------
module mppi_weighted_control_update_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mwcu_pkg::*;

    localparam int SAMPLES = 512;
    localparam int HORIZON = 128;
    localparam int SETTLE  = 64;

    typedef struct {
        logic [1:0]         mode;
        logic [8:0]         sample_index;
        logic [6:0]         step_index;
        logic signed [31:0] cost;
        logic signed [15:0] speed_sample;
        logic signed [15:0] turn_sample;
        logic               first_sample;
    } beat_t;

    typedef struct {
        beat_t              b;
        bit                 typed;
        logic signed [15:0] speed;
        logic signed [15:0] turn;
    } row_t;

    typedef struct {
        logic signed [15:0] speed;
        logic signed [15:0] turn;
    } opt_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    mwcu_item_if   item_ch ();
    mwcu_result_if result_ch ();

    mppi_weighted_control_update dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    // model state
    logic [15:0]        inv_lambda_r;
    logic signed [15:0] speed_lo, speed_hi, turn_lo, turn_hi;
    logic signed [31:0] cost_mem [SAMPLES];
    bit                 cost_written [SAMPLES];
    logic signed [31:0] lowest_cost;
    logic [31:0]        weight_sum;
    logic [15:0]        cur_weight;
    logic [47:0]        speed_acc [HORIZON];
    logic [47:0]        turn_acc [HORIZON];

    const longint unsigned exp2_tab [17] = '{
        65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
        46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
    };

    opt_t opt_expected [$];
    int   errors = 0;
    int   burst_left = 0;
    int   rx_cycle = 0;
    int   stall_kind = 0;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [15:0] sample_weight(logic signed [31:0] c);
        longint d;
        longint unsigned x, y, m;
        longint unsigned n, f, k, r;
        d = longint'(c) - longint'(lowest_cost);
        if (d <= 0)
            return 16'hffff;
        x = d * longint'(inv_lambda_r);
        if (x >= 64'd786432)
            return 16'd0;
        y = (x * 64'd94548) >> 16;
        n = y >> 16;
        f = y & 64'hffff;
        k = f >> 12;
        r = f & 64'hfff;
        m = exp2_tab[k] - (((exp2_tab[k] - exp2_tab[k + 1]) * r) >> 12);
        m = m >> n;
        return (m > 65535) ? 16'hffff : m[15:0];
    endfunction

    function automatic logic signed [15:0] step_average(logic [47:0] acc,
                                                        logic signed [15:0] lo,
                                                        logic signed [15:0] hi);
        longint q;
        q = 0;
        if (weight_sum != 0)
            q = longint'($signed(acc)) / longint'({32'd0, weight_sum});
        if (q < longint'(lo))
            q = longint'(lo);
        if (q > longint'(hi))
            q = longint'(hi);
        return q[15:0];
    endfunction

    function automatic void clear_run();
        lowest_cost = COST_MAX;
        weight_sum = '0;
        for (int i = 0; i < HORIZON; i++)
        begin
            speed_acc[i] = '0;
            turn_acc[i] = '0;
        end
    endfunction

    // apply one accepted beat to the model; returns the read result if any
    function automatic bit update_model(beat_t b, output opt_t o);
        longint p;
        o = '{0, 0};
        if (b.mode == MODE_NONE)
            return 0;
        if (b.first_sample)
            clear_run();
        case (b.mode)
            MODE_COST:
            begin
                cost_mem[b.sample_index] = b.cost;
                cost_written[b.sample_index] = 1;
                if (b.cost < lowest_cost)
                    lowest_cost = b.cost;
                return 0;
            end
            MODE_CTRL:
            begin
                if (b.step_index == 0)
                begin
                    cur_weight = sample_weight(cost_mem[b.sample_index]);
                    weight_sum = weight_sum + 32'(cur_weight);
                end
                p = longint'(cur_weight) * longint'(b.speed_sample);
                speed_acc[b.step_index] = speed_acc[b.step_index] + p[47:0];
                p = longint'(cur_weight) * longint'(b.turn_sample);
                turn_acc[b.step_index] = turn_acc[b.step_index] + p[47:0];
                return 0;
            end
            default:
            begin
                o.speed = step_average(speed_acc[b.step_index], speed_lo, speed_hi);
                o.turn = step_average(turn_acc[b.step_index], turn_lo, turn_hi);
                return 1;
            end
        endcase
    endfunction

    task automatic send_beat(beat_t b, bit typed = 0, opt_t typed_opt = '{0, 0});
        opt_t o;
        if (burst_left == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
        end
        burst_left--;
        item_ch.valid        <= 1'b1;
        item_ch.mode         <= b.mode;
        item_ch.sample_index <= b.sample_index;
        item_ch.step_index   <= b.step_index;
        item_ch.cost         <= b.cost;
        item_ch.speed_sample <= b.speed_sample;
        item_ch.turn_sample  <= b.turn_sample;
        item_ch.first_sample <= b.first_sample;
        do
            @(posedge clk);
        while (!item_ch.ready);
        if (update_model(b, o))
            opt_expected.insert(opt_expected.size(), typed ? typed_opt : o);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        while (opt_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_INV_LAMBDA: inv_lambda_r = val;
            REG_SPEED_MIN:  speed_lo = val;
            REG_SPEED_MAX:  speed_hi = val;
            REG_TURN_MIN:   turn_lo = val;
            default:        turn_hi = val;
        endcase
    endtask

    function automatic beat_t mk(logic [1:0] m, int s, int t, int c, int sp, int tu,
                                 bit first);
        beat_t b;
        b.mode = m;
        b.sample_index = 9'(s);
        b.step_index = 7'(t);
        b.cost = c;
        b.speed_sample = 16'(sp);
        b.turn_sample = 16'(tu);
        b.first_sample = first;
        return b;
    endfunction

    // a well-formed run: costs, control pairs sample-major, then reads
    task automatic send_run(ref int sent);
        int n_samp, n_step, spread, n_read;
        int base;
        int idx [8];
        n_samp = $urandom_range(1, 8);
        n_step = $urandom_range(1, 6);
        case ($urandom_range(0, 3))
            0:       spread = 0;
            1:       spread = 40;
            2:       spread = 3000;
            default: spread = 32'h3fff_ffff;
        endcase
        base = $urandom_range(0, 1) ? int'($urandom) : int'($urandom_range(0, 2000)) - 1000;
        for (int i = 0; i < n_samp; i++)
        begin
            idx[i] = $urandom_range(0, SAMPLES - 1);
            send_beat(mk(MODE_COST, idx[i], $urandom, base + $urandom_range(0, spread),
                         $urandom, $urandom, i == 0));
            sent++;
        end
        for (int i = 0; i < n_samp; i++)
            for (int t = 0; t < n_step; t++)
            begin
                send_beat(mk(MODE_CTRL, idx[i], t, $urandom, $urandom, $urandom, 0));
                sent++;
            end
        n_read = $urandom_range(1, 4);
        for (int i = 0; i < n_read; i++)
        begin
            send_beat(mk(MODE_READ, $urandom, $urandom_range(0, n_step), $urandom,
                         $urandom, $urandom, 0));
            sent++;
        end
    endtask

    task automatic send_noise();
        beat_t b;
        b = mk(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom_range(0, 7) == 0);
        // never form a weight from a cost slot that was never loaded
        if (b.mode == MODE_CTRL && b.step_index == 0 && !cost_written[b.sample_index])
            b.step_index = 1;
        send_beat(b);
    endtask

    // receiver stall pattern is picked at random and changes over the run
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 300 == 0)
            stall_kind <= $urandom_range(0, 2);
        case (stall_kind)
            0:       result_ch.ready <= 1'b1;
            1:       result_ch.ready <= 1'($urandom_range(0, 1));
            default: result_ch.ready <= (rx_cycle % 7 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        opt_t e;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (opt_expected.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                e = opt_expected.pop_front();
                if (result_ch.speed_opt !== e.speed)
                begin
                    $error("speed_opt: expected %0d, got %0d", e.speed, result_ch.speed_opt);
                    errors++;
                end
                if (result_ch.turn_opt !== e.turn)
                begin
                    $error("turn_opt: expected %0d, got %0d", e.turn, result_ch.turn_opt);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        row_t rows [$];
        logic [15:0] cfg_set [5][5];
        logic signed [15:0] a, b;
        int sent;

        item_ch.valid = 1'b0;
        item_ch.mode = MODE_NONE;
        item_ch.sample_index = '0;
        item_ch.step_index = '0;
        item_ch.cost = '0;
        item_ch.speed_sample = '0;
        item_ch.turn_sample = '0;
        item_ch.first_sample = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_INV_LAMBDA;
        cfg_data = '0;
        rst_n = 1'b0;

        inv_lambda_r = INV_LAMBDA_RST;
        speed_lo = SPEED_MIN_RST;
        speed_hi = SPEED_MAX_RST;
        turn_lo = TURN_MIN_RST;
        turn_hi = TURN_MAX_RST;
        cur_weight = '0;
        for (int i = 0; i < SAMPLES; i++)
        begin
            cost_mem[i] = '0;
            cost_written[i] = 0;
        end
        clear_run();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            '{mk(MODE_READ, 0, 0, 0, 0, 0, 0), 1, 0, 0},
            '{mk(MODE_NONE, 511, 127, -1, -1, -1, 1), 0, 0, 0},
            // empty weight sum
            '{mk(MODE_READ, 0, 127, 0, 0, 0, 1), 1, 0, 0},
            '{mk(MODE_COST, 0, 0, 32'sh8000_0000, 0, 0, 1), 0, 0, 0},
            '{mk(MODE_COST, 511, 0, 32'sh7fff_ffff, 0, 0, 0), 0, 0, 0},
            '{mk(MODE_COST, 1, 0, 0, 0, 0, 0), 0, 0, 0},
            '{mk(MODE_CTRL, 0, 0, 0, 32767, -32768, 0), 0, 0, 0},
            '{mk(MODE_CTRL, 0, 127, 0, -32768, 32767, 0), 0, 0, 0},
            // weight underflows to zero
            '{mk(MODE_CTRL, 511, 0, 0, 1, 1, 0), 0, 0, 0},
            '{mk(MODE_CTRL, 1, 0, 0, 100, -100, 0), 0, 0, 0},
            '{mk(MODE_READ, 0, 0, 0, 0, 0, 0), 1, 4096, -3686},
            '{mk(MODE_READ, 0, 127, 0, 0, 0, 0), 1, -410, 3686},
            '{mk(MODE_READ, 0, 5, 0, 0, 0, 0), 0, 0, 0},
            '{mk(MODE_COST, 3, 0, 50, 0, 0, 1), 0, 0, 0},
            // stale lower cost gets full weight
            '{mk(MODE_CTRL, 0, 0, 0, 1000, -1000, 0), 0, 0, 0},
            '{mk(MODE_CTRL, 3, 0, 0, 2000, 2000, 0), 0, 0, 0},
            '{mk(MODE_CTRL, 3, 1, 0, -5, 7, 0), 0, 0, 0},
            '{mk(MODE_READ, 0, 0, 0, 0, 0, 0), 0, 0, 0},
            '{mk(MODE_READ, 0, 1, 0, 0, 0, 0), 0, 0, 0},
            '{mk(MODE_COST, 4, 0, 60, 0, 0, 0), 0, 0, 0},
            '{mk(MODE_CTRL, 4, 0, 0, 4096, -4096, 0), 0, 0, 0},
            '{mk(MODE_READ, 0, 0, 0, 0, 0, 0), 0, 0, 0}
        };
        foreach (rows[i])
            send_beat(rows[i].b, rows[i].typed, '{rows[i].speed, rows[i].turn});

        cfg_set[0] = '{16'd1, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
        cfg_set[1] = '{16'hffff, 16'h7fff, 16'h8000, 16'd100, -16'sd100};
        a = 16'($urandom); b = 16'($urandom);
        cfg_set[2] = '{16'($urandom_range(1, 64)), (a < b) ? a : b, (a < b) ? b : a,
                       -16'sd2000, 16'sd2000};
        cfg_set[3] = '{16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom)};
        cfg_set[4] = '{INV_LAMBDA_RST, SPEED_MIN_RST, SPEED_MAX_RST, TURN_MIN_RST,
                       TURN_MAX_RST};

        for (int p = 0; p < 5; p++)
        begin
            drain();
            write_reg(REG_INV_LAMBDA, cfg_set[p][0]);
            write_reg(REG_SPEED_MIN, cfg_set[p][1]);
            write_reg(REG_SPEED_MAX, cfg_set[p][2]);
            write_reg(REG_TURN_MIN, cfg_set[p][3]);
            write_reg(REG_TURN_MAX, cfg_set[p][4]);
            sent = 0;
            while (sent < 250)
            begin
                if ($urandom_range(0, 4) != 0)
                    send_run(sent);
                else
                begin
                    send_noise();
                    sent++;
                end
                // hold off once until the pipe is empty
                if (p == 2 && sent >= 125 && sent < 140)
                begin
                    drain();
                    sent = 140;
                end
            end
        end

        drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
hdl/mwcu_pkg.sv
hdl/mwcu_if.sv
hdl/mwcu_ram.sv
hdl/mwcu_div.sv
hdl/mppi_weighted_control_update.sv
hdl/mwcu_checker.sv
verif/mppi_weighted_control_update_tb.sv
